// ===== design/mlm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlm_pkg: shared types and constants for the multipass lock manager
// Word formats for the command and result channels, mode codes and defaults.
// ----------------------------------------------------------------------------
package mlm_pkg;

	// parameter defaults
	localparam int LOCK_COUNT_DEF = 32;
	localparam int MAX_PASSES_DEF = 8;
	localparam int ID_BITS_DEF    = 32;

	// field widths fixed by the word formats
	localparam int MASK_W  = 32;
	localparam int ID_W    = 32;
	localparam int PIDX_W  = 3;
	localparam int PCNT_W  = 4;
	localparam int MODE_W  = 2;

	// smallest pass count that takes the whole-pipe holder
	localparam logic [PCNT_W-1:0] MULTI_PASS_MIN = PCNT_W'(2);

	// lock modes; the unused code behaves as acquire with undo
	localparam logic [MODE_W-1:0] MODE_HOLDER = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UNDO   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_RESET  = MODE_UNDO;

	// command word
	typedef struct packed {
		logic [ID_W-1:0]   txn_id;
		logic [PIDX_W-1:0] pass_index;
		logic [PCNT_W-1:0] pass_count;
		logic [MASK_W-1:0] check_mask;
		logic [MASK_W-1:0] wanted_mask;
		logic [MASK_W-1:0] undo_in;
	} item_word_t;

	// result word
	typedef struct packed {
		logic              granted;
		logic [MASK_W-1:0] undo_out;
		logic              fail_increment;
		logic              consistency_error;
	} result_word_t;

endpackage : mlm_pkg
`default_nettype wire

// ===== design/mlm_decide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlm_decide: lock decision for one pass
// Computes the result word and the next lock and holder state from the
// registered pass and the current state.
// ----------------------------------------------------------------------------
module mlm_decide #(
	parameter int LW         = 32,
	parameter int IW         = 32,
	parameter int MAX_PASSES = 8
) (
	input  wire logic [1:0]          mode,
	input  wire mlm_pkg::item_word_t item,
	input  wire logic [LW-1:0]       held,
	input  wire logic                holder_valid,
	input  wire logic [IW-1:0]       holder_id,
	output mlm_pkg::result_word_t    result,
	output logic [LW-1:0]            held_next,
	output logic                     holder_valid_next,
	output logic [IW-1:0]            holder_id_next
);
	import mlm_pkg::*;

	logic [LW-1:0]     chk;
	logic [LW-1:0]     want;
	logic [LW-1:0]     undo;
	logic [IW-1:0]     id;
	logic              pass_last;
	logic              pass_first;

	assign chk  = item.check_mask[LW-1:0];
	assign want = item.wanted_mask[LW-1:0];
	assign undo = item.undo_in[LW-1:0];
	assign id   = item.txn_id[IW-1:0];

	// last pass only for a pass count within range
	assign pass_last = (32'(item.pass_count) <= 32'(MAX_PASSES)) &&
		((PCNT_W'(item.pass_index) + PCNT_W'(1)) == item.pass_count);
	assign pass_first = (item.pass_index == '0);

	// decision
	always_comb begin
		result.granted           = 1'b1;
		result.undo_out          = item.undo_in;
		result.fail_increment    = 1'b0;
		result.consistency_error = 1'b0;
		held_next                = held;
		holder_valid_next        = holder_valid;
		holder_id_next           = holder_id;
		case (mode)
			MODE_HOLDER: begin
				if (!holder_valid) begin
					if (item.pass_count >= MULTI_PASS_MIN) begin
						holder_valid_next = 1'b1;
						holder_id_next    = id;
					end
				end else if (holder_id == id) begin
					if (pass_last) holder_valid_next = 1'b0;
				end else begin
					result.granted = 1'b0;
				end
			end
			MODE_CHECK: begin
				if (pass_first) begin
					if ((held & chk) == '0) begin
						result.consistency_error = ((held & want) != '0);
						held_next = held | want;
					end else begin
						result.granted = 1'b0;
					end
				end else if (pass_last) begin
					result.consistency_error = ((held & want) != want);
					held_next = held ^ want;
				end
			end
			default: begin
				if (pass_first) begin
					if (undo == '0) begin
						held_next = held | want;
						if ((held & chk) == '0) begin
							result.consistency_error = ((held & want) != '0);
						end else begin
							result.undo_out       = MASK_W'(~held & want);
							result.fail_increment = 1'b1;
							result.granted        = 1'b0;
						end
					end else begin
						// recirculated pass clears what a failed attempt set
						result.consistency_error = ((held & undo) != undo);
						held_next       = held ^ undo;
						result.undo_out = '0;
						result.granted  = 1'b0;
					end
				end else if (pass_last) begin
					result.consistency_error = ((held & want) != want);
					held_next = held ^ want;
				end
			end
		endcase
	end

endmodule : mlm_decide
`default_nettype wire

// ===== design/multipass_lock_manager_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// multipass_lock_manager_core: lock table for multi-pass transactions
// Grants or recirculates each pass and keeps the held-lock and holder state.
// ----------------------------------------------------------------------------
// One pass is taken every cycle (busy stays low). A pass accepted at an edge
// is registered, decided against the lock state in the next cycle, and its
// result is registered and strobed on result_valid in the cycle after that.
// One pass is handled per cycle, a rate set by the single decision stage
// that reads and writes the lock state. The result is shown for exactly one
// cycle and cannot be held off. The user must write lock_mode through
// cfg_valid/cfg_ready only while no pass is in flight; the block does not enforce this.
module multipass_lock_manager_core #(
	parameter int LOCK_COUNT = mlm_pkg::LOCK_COUNT_DEF,
	parameter int MAX_PASSES = mlm_pkg::MAX_PASSES_DEF,
	parameter int ID_BITS    = mlm_pkg::ID_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire mlm_pkg::item_word_t   item,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_data,
	output logic                       result_valid,
	output mlm_pkg::result_word_t      result
);
	import mlm_pkg::*;

	localparam int LW = (LOCK_COUNT < MASK_W) ? LOCK_COUNT : MASK_W;
	localparam int IW = (ID_BITS < ID_W) ? ID_BITS : ID_W;

	logic [MODE_W-1:0] mode_q;
	item_word_t        item_s1;
	logic              valid_s1;
	logic [LW-1:0]     held_q;
	logic              holder_valid_q;
	logic [IW-1:0]     holder_id_q;
	result_word_t      result_q;
	logic              result_valid_q;

	result_word_t      dec_result;
	logic [LW-1:0]     held_next;
	logic              holder_valid_next;
	logic [IW-1:0]     holder_id_next;

	assign busy         = 1'b0;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) item_s1 <= item;
	end

	mlm_decide #(
		.LW(LW),
		.IW(IW),
		.MAX_PASSES(MAX_PASSES)
	) u_decide (
		.mode(mode_q),
		.item(item_s1),
		.held(held_q),
		.holder_valid(holder_valid_q),
		.holder_id(holder_id_q),
		.result(dec_result),
		.held_next(held_next),
		.holder_valid_next(holder_valid_next),
		.holder_id_next(holder_id_next)
	);

	// lock state, updated once per decided pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q         <= '0;
			holder_valid_q <= 1'b0;
			holder_id_q    <= '0;
		end else if (valid_s1) begin
			held_q         <= held_next;
			holder_valid_q <= holder_valid_next;
			holder_id_q    <= holder_id_next;
		end
	end

	// result register, one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) result_q <= dec_result;
	end

	// every registered pass yields a result in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> result_valid)
		else $error("registered pass produced no result");

	// lock state moves only when a pass is decided
	a_state_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> ($stable(held_q) && $stable(holder_valid_q)))
		else $error("lock state changed with no pass");

	// a failed attempt never proceeds
	a_fail_recirc: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.fail_increment) |-> !result.granted)
		else $error("failed attempt granted");

	// whole-pipe mode reports no failure and no inconsistency
	a_holder_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && mode_q == MODE_HOLDER) |=>
		(!result.fail_increment && !result.consistency_error))
		else $error("flags set in whole-pipe mode");

endmodule : multipass_lock_manager_core
`default_nettype wire
